[rtl/core/kpu_pkg.sv]
// shared types, constants and factorial table for the permutation unrank core
package kpu_pkg;

  localparam int MAX_N        = 20;
  localparam int RANK_W       = 62;
  localparam int SIZE_W       = 5;
  localparam int QUOT_W       = 5;
  localparam int MASK_W       = MAX_N;
  localparam int STEP_W       = 3;
  localparam int TRIAL_W      = RANK_W + QUOT_W - 1;
  localparam logic [SIZE_W-1:0] PERM_SIZE_RST = 5'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SEL
  } kpu_state_t;

  // factorial of 0..20
  function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] i);
    logic [RANK_W-1:0] f;
    case (i)
      5'd0:    f = 62'd1;
      5'd1:    f = 62'd1;
      5'd2:    f = 62'd2;
      5'd3:    f = 62'd6;
      5'd4:    f = 62'd24;
      5'd5:    f = 62'd120;
      5'd6:    f = 62'd720;
      5'd7:    f = 62'd5040;
      5'd8:    f = 62'd40320;
      5'd9:    f = 62'd362880;
      5'd10:   f = 62'd3628800;
      5'd11:   f = 62'd39916800;
      5'd12:   f = 62'd479001600;
      5'd13:   f = 62'd6227020800;
      5'd14:   f = 62'd87178291200;
      5'd15:   f = 62'd1307674368000;
      5'd16:   f = 62'd20922789888000;
      5'd17:   f = 62'd355687428096000;
      5'd18:   f = 62'd6402373705728000;
      5'd19:   f = 62'd121645100408832000;
      5'd20:   f = 62'd2432902008176640000;
      default: f = 62'd2432902008176640000;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/kth_permutation_unrank_core.sv]
// k-th lexicographic permutation unrank core, factoradic method
// each accepted rank passes a check state, then per element the shared 5-step
// restoring compare-subtract unit and one selection state that emits the element;
// a new rank is taken only when idle (busy low); a bad rank gives its single
// error result from the check state; results cannot be stalled
// synchronous active-low reset returns to idle with permutation size 4
module kth_permutation_unrank_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [kpu_pkg::RANK_W-1:0]    in_rank,
  output logic                          out_valid,
  output logic [kpu_pkg::SIZE_W-1:0]    out_element,
  output logic                          out_last,
  output logic                          out_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpu_pkg::SIZE_W-1:0]    cfg_data
);

  kpu_pkg::kpu_state_t state_r, state_nxt;

  logic [kpu_pkg::SIZE_W-1:0]  perm_size_r;
  logic [kpu_pkg::SIZE_W-1:0]  eff_size;
  logic [kpu_pkg::SIZE_W-1:0]  n_r, n_nxt;
  logic [kpu_pkg::RANK_W-1:0]  rem_r, rem_nxt;
  logic [kpu_pkg::TRIAL_W-1:0] trial_r, trial_nxt;
  logic [kpu_pkg::QUOT_W-1:0]  quot_r, quot_nxt;
  logic [kpu_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [kpu_pkg::SIZE_W-1:0]  pos_r, pos_nxt;
  logic [kpu_pkg::MASK_W-1:0]  mask_r, mask_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [kpu_pkg::SIZE_W-1:0]  out_element_r, out_element_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_error_r, out_error_nxt;

  logic [kpu_pkg::SIZE_W-1:0]  sel_idx;
  logic                        ge;
  logic                        pos_last;

  assign busy      = (state_r != kpu_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;
  assign out_error   = out_error_r;

  // size clamp to 1..MAX_N
  always_comb begin
    if (perm_size_r == '0) begin
      eff_size = 5'd1;
    end else if (perm_size_r > kpu_pkg::SIZE_W'(kpu_pkg::MAX_N)) begin
      eff_size = kpu_pkg::SIZE_W'(kpu_pkg::MAX_N);
    end else begin
      eff_size = perm_size_r;
    end
  end

  // q-th unused value
  kpu_select u_select (
    .mask (mask_r),
    .quot (quot_r),
    .idx  (sel_idx)
  );

  // shared compare-subtract unit
  assign ge       = ({{(kpu_pkg::QUOT_W-1){1'b0}}, rem_r} >= trial_r);
  assign pos_last = (pos_r == (n_r - 5'd1));

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    rem_nxt         = rem_r;
    trial_nxt       = trial_r;
    quot_nxt        = quot_r;
    step_nxt        = step_r;
    pos_nxt         = pos_r;
    mask_nxt        = mask_r;
    out_valid_nxt   = 1'b0;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    out_error_nxt   = out_error_r;
    case (state_r)
      kpu_pkg::ST_IDLE: begin
        if (start) begin
          rem_nxt   = in_rank;
          n_nxt     = eff_size;
          state_nxt = kpu_pkg::ST_CHECK;
        end
      end
      kpu_pkg::ST_CHECK: begin
        if ((rem_r == '0) || (rem_r > kpu_pkg::fact(n_r))) begin
          out_valid_nxt   = 1'b1;
          out_element_nxt = '0;
          out_last_nxt    = 1'b1;
          out_error_nxt   = 1'b1;
          state_nxt       = kpu_pkg::ST_IDLE;
        end else begin
          rem_nxt   = rem_r - 62'd1;
          mask_nxt  = kpu_pkg::MASK_W'(~({kpu_pkg::MASK_W{1'b1}} << n_r));
          pos_nxt   = '0;
          trial_nxt = {kpu_pkg::fact(n_r - 5'd1), {(kpu_pkg::QUOT_W-1){1'b0}}};
          quot_nxt  = '0;
          step_nxt  = kpu_pkg::STEP_W'(kpu_pkg::QUOT_W - 1);
          state_nxt = kpu_pkg::ST_DIV;
        end
      end
      kpu_pkg::ST_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - trial_r[kpu_pkg::RANK_W-1:0];
        end
        quot_nxt  = {quot_r[kpu_pkg::QUOT_W-2:0], ge};
        trial_nxt = trial_r >> 1;
        step_nxt  = step_r - 3'd1;
        if (step_r == '0) begin
          state_nxt = kpu_pkg::ST_SEL;
        end
      end
      kpu_pkg::ST_SEL: begin
        out_valid_nxt   = 1'b1;
        out_element_nxt = sel_idx + 5'd1;
        out_last_nxt    = pos_last;
        out_error_nxt   = 1'b0;
        mask_nxt        = mask_r & ~(kpu_pkg::MASK_W'(1) << sel_idx);
        if (pos_last) begin
          state_nxt = kpu_pkg::ST_IDLE;
        end else begin
          pos_nxt   = pos_r + 5'd1;
          trial_nxt = {kpu_pkg::fact(n_r - 5'd2 - pos_r),
                       {(kpu_pkg::QUOT_W-1){1'b0}}};
          quot_nxt  = '0;
          step_nxt  = kpu_pkg::STEP_W'(kpu_pkg::QUOT_W - 1);
          state_nxt = kpu_pkg::ST_DIV;
        end
      end
      default: begin
        state_nxt = kpu_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kpu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      perm_size_r <= kpu_pkg::PERM_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        perm_size_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r           <= n_nxt;
    rem_r         <= rem_nxt;
    trial_r       <= trial_nxt;
    quot_r        <= quot_nxt;
    step_r        <= step_nxt;
    pos_r         <= pos_nxt;
    mask_r        <= mask_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
    out_error_r   <= out_error_nxt;
  end

endmodule

[rtl/core/kpu_select.sv]
// picks the q-th (from zero) set bit of the unused mask, highest set bit if q is too large
module kpu_select (
  input  logic [kpu_pkg::MASK_W-1:0] mask,
  input  logic [kpu_pkg::QUOT_W-1:0] quot,
  output logic [kpu_pkg::SIZE_W-1:0] idx
);

  logic [kpu_pkg::MASK_W-1:0] hit;
  logic [kpu_pkg::SIZE_W:0]   cnt [kpu_pkg::MASK_W];
  logic [kpu_pkg::SIZE_W:0]   target;
  logic [kpu_pkg::SIZE_W-1:0] hit_idx;
  logic [kpu_pkg::SIZE_W-1:0] top_idx;

  // prefix counts per bit, each independent
  always_comb begin
    target = {1'b0, quot} + 6'd1;
    for (int i = 0; i < kpu_pkg::MASK_W; i++) begin
      cnt[i] = (kpu_pkg::SIZE_W+1)'($countones(mask &
               ~({kpu_pkg::MASK_W{1'b1}} << (i + 1))));
      hit[i] = mask[i] && (cnt[i] == target);
    end
  end

  // one-hot hit to index, plus highest set bit for saturation
  always_comb begin
    hit_idx = '0;
    top_idx = '0;
    for (int i = 0; i < kpu_pkg::MASK_W; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | kpu_pkg::SIZE_W'(i);
      end
      if (mask[i]) begin
        top_idx = kpu_pkg::SIZE_W'(i);
      end
    end
    idx = (|hit) ? hit_idx : top_idx;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the k-th permutation unrank core
module testbench;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PHASE_ITEMS    = 35;

  typedef struct packed {
    logic [kpu_pkg::SIZE_W-1:0] element;
    logic                       last;
    logic                       error;
  } perm_entry_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [kpu_pkg::RANK_W-1:0] in_rank = '0;
  logic                       out_valid;
  logic [kpu_pkg::SIZE_W-1:0] out_element;
  logic                       out_last;
  logic                       out_error;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [kpu_pkg::SIZE_W-1:0] cfg_data = '0;

  // permutation elements still owed by the core, oldest first
  perm_entry_t                expected_elems[$];
  logic [kpu_pkg::SIZE_W-1:0] model_perm_size = kpu_pkg::PERM_SIZE_RST;
  int                         idle_pct = 0;
  int                         mismatch_count = 0;
  int                         idle_cycles = 0;

  always #2 clk = ~clk;

  kth_permutation_unrank_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_rank     (in_rank),
    .out_valid   (out_valid),
    .out_element (out_element),
    .out_last    (out_last),
    .out_error   (out_error),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  function automatic longint unsigned factorial_u64(int n);
    longint unsigned f;
    f = 1;
    for (int i = 2; i <= n; i++) f = f * i;
    return f;
  endfunction

  // size 0 behaves as 1, sizes above MAX_N behave as MAX_N
  function automatic int effective_size(logic [kpu_pkg::SIZE_W-1:0] size);
    int n;
    n = size;
    if (n < 1) n = 1;
    if (n > kpu_pkg::MAX_N) n = kpu_pkg::MAX_N;
    return n;
  endfunction

  // factoradic decode of one rank into the expected element stream
  function automatic void unrank_into_queue(logic [kpu_pkg::RANK_W-1:0] rank);
    int                        n;
    int                        v;
    int                        seen;
    longint unsigned           rem;
    longint unsigned           d;
    longint unsigned           q;
    logic [kpu_pkg::MAX_N-1:0] unused;
    perm_entry_t               e;
    n = effective_size(model_perm_size);
    // zero rank or rank beyond n! yields one error entry
    if (rank == '0 || 64'(rank) > factorial_u64(n)) begin
      e.element = '0;
      e.last    = 1'b1;
      e.error   = 1'b1;
      expected_elems = {expected_elems, e};
      return;
    end
    unused = '0;
    for (int i = 0; i < n; i++) unused[i] = 1'b1;
    rem = 64'(rank) - 1;
    for (int pos = 0; pos < n; pos++) begin
      d   = factorial_u64(n - 1 - pos);
      q   = rem / d;
      rem = rem - q * d;
      // q-th smallest unused value, saturating to the largest unused one
      v    = 0;
      seen = 0;
      for (int i = 0; i < kpu_pkg::MAX_N; i++) begin
        if (unused[i]) begin
          v = i;
          if (longint'(seen) == q) break;
          seen++;
        end
      end
      unused[v] = 1'b0;
      e.element = kpu_pkg::SIZE_W'(v + 1);
      e.last    = (pos == n - 1);
      e.error   = 1'b0;
      expected_elems = {expected_elems, e};
    end
  endfunction

  function automatic logic [kpu_pkg::RANK_W-1:0] random_rank62();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[kpu_pkg::RANK_W-1:0];
  endfunction

  // mostly in-range ranks, some boundary ranks, some raw 62-bit noise
  function automatic logic [kpu_pkg::RANK_W-1:0] random_rank_for_size();
    longint unsigned f;
    longint unsigned r;
    int              pick;
    f    = factorial_u64(effective_size(model_perm_size));
    pick = $urandom_range(99);
    if (pick < 70) begin
      r = {$urandom, $urandom};
      return kpu_pkg::RANK_W'(r % f + 1);
    end else if (pick < 82) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return kpu_pkg::RANK_W'(1);
        2:       return kpu_pkg::RANK_W'(f);
        default: return kpu_pkg::RANK_W'(f + 1);
      endcase
    end
    return random_rank62();
  endfunction

  // one rank transfer on the start/busy handshake
  task automatic send_rank(logic [kpu_pkg::RANK_W-1:0] rank);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    @(negedge clk);
    start   <= 1'b1;
    in_rank <= rank;
    do @(posedge clk); while (busy);
    unrank_into_queue(rank);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // size register is only written with the core idle
  task automatic write_perm_size(logic [kpu_pkg::SIZE_W-1:0] size);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    model_perm_size = size;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reset size of 4: first, last, middle and out-of-range ranks
  task automatic test_default_size();
    send_rank(kpu_pkg::RANK_W'(1));
    send_rank(kpu_pkg::RANK_W'(2));
    send_rank(kpu_pkg::RANK_W'(13));
    send_rank(kpu_pkg::RANK_W'(24));
    send_rank(kpu_pkg::RANK_W'(25));
    send_rank('0);
    send_rank('1);
  endtask

  // size one, and size zero treated as one
  task automatic test_size_one();
    write_perm_size(kpu_pkg::SIZE_W'(1));
    send_rank(kpu_pkg::RANK_W'(1));
    send_rank(kpu_pkg::RANK_W'(2));
    send_rank('0);
    write_perm_size('0);
    send_rank(kpu_pkg::RANK_W'(1));
    send_rank(kpu_pkg::RANK_W'(2));
  endtask

  // largest size, and oversize clamped to the largest
  task automatic test_size_max();
    write_perm_size(kpu_pkg::SIZE_W'(kpu_pkg::MAX_N));
    send_rank(kpu_pkg::RANK_W'(1));
    send_rank(kpu_pkg::RANK_W'(factorial_u64(kpu_pkg::MAX_N)));
    send_rank(kpu_pkg::RANK_W'(factorial_u64(kpu_pkg::MAX_N) / 2 + 12345));
    send_rank(kpu_pkg::RANK_W'(factorial_u64(kpu_pkg::MAX_N) + 1));
    write_perm_size('1);
    send_rank(kpu_pkg::RANK_W'(1));
    send_rank(kpu_pkg::RANK_W'(factorial_u64(kpu_pkg::MAX_N)));
    send_rank('1);
  endtask

  task automatic test_small_sizes();
    write_perm_size(kpu_pkg::SIZE_W'(2));
    send_rank(kpu_pkg::RANK_W'(1));
    send_rank(kpu_pkg::RANK_W'(2));
    write_perm_size(kpu_pkg::SIZE_W'(3));
    send_rank(kpu_pkg::RANK_W'(4));
    send_rank(kpu_pkg::RANK_W'(6));
    send_rank(kpu_pkg::RANK_W'(7));
  endtask

  // random ranks over several sizes and sender idle rates
  task automatic test_random_traffic();
    int idle_rates[3] = '{0, 81, 27};
    for (int p = 0; p < 3; p++) begin
      idle_pct = idle_rates[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 12 == 0) begin
          if ($urandom_range(4) == 0) begin
            write_perm_size(kpu_pkg::SIZE_W'($urandom_range(31)));
          end else begin
            write_perm_size(kpu_pkg::SIZE_W'($urandom_range(8, 1)));
          end
        end
        // hold off until the core has delivered everything
        if (k == PHASE_ITEMS / 2) drain_results();
        send_rank(random_rank_for_size());
      end
    end
    idle_pct = 0;
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    perm_entry_t want;
    if (rst_n && out_valid) begin
      if (expected_elems.size() == 0) begin
        $error("unexpected result: element %0d last %0b error %0b",
               out_element, out_last, out_error);
        mismatch_count++;
      end else begin
        want = expected_elems.pop_front();
        if (out_element !== want.element) begin
          $error("element: expected %0d, got %0d", want.element, out_element);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          mismatch_count++;
        end
        if (out_error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_error);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_size();
    test_size_one();
    test_size_max();
    test_small_sizes();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
